// ----- hdl/blhm_pkg.sv -----
// shared widths, register indexes, reset values and types of the battery level monitor
package blhm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 16;
  localparam int MV_W       = 13;
  localparam int LVL_W      = 3;
  localparam int THR_W      = 13;
  localparam int HYST_W     = 8;
  localparam int OFS_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int NUM_THR    = 4;

  localparam int SAMPLES_PER_READING_DEF = 10;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THR0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;

  // register reset values
  localparam logic [THR_W-1:0]  THR0_RST   = 13'd3450;
  localparam logic [THR_W-1:0]  THR1_RST   = 13'd3600;
  localparam logic [THR_W-1:0]  THR2_RST   = 13'd3750;
  localparam logic [THR_W-1:0]  THR3_RST   = 13'd3900;
  localparam logic [HYST_W-1:0] HYST_RST   = 8'd30;
  localparam logic [OFS_W-1:0]  OFFSET_RST = 9'd130;

  // battery levels
  localparam logic [LVL_W-1:0] LEVEL_0 = 3'd0;
  localparam logic [LVL_W-1:0] LEVEL_1 = 3'd1;
  localparam logic [LVL_W-1:0] LEVEL_2 = 3'd2;
  localparam logic [LVL_W-1:0] LEVEL_3 = 3'd3;
  localparam logic [LVL_W-1:0] LEVEL_4 = 3'd4;

  // mV = sum * 1100 / (1024 * n) = sum * 275 / (256 * n)
  localparam int MV_NUM       = 275;
  localparam int MV_DEN_SHIFT = 8;

  typedef struct packed {
    logic [NUM_THR-1:0][THR_W-1:0] thr;
    logic [HYST_W-1:0]             hyst;
    logic [OFS_W-1:0]              offset;
  } blhm_cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             usb;
  } blhm_group_t;

endpackage

// ----- hdl/battery_level_hysteresis_monitor.sv -----
// top level of the battery level monitor with hysteresis
// Takes one 12-bit ADC sample per cycle and sums SAMPLES_PER_READING samples into
// a group; each completed group gives one request on the output carrying the
// voltage in mV, floor(sum * 1100 / (1024 * SAMPLES_PER_READING)), less
// charge_offset_mv (floored at zero) when usb_plugged is set on the group's last
// sample, and the battery level 0..4. The first reading after reset takes the
// level from the plain thresholds; later readings step at most one level, with
// hysteresis_mv of margin around each threshold. Input requests are taken every
// cycle; the group, scaling and result registers load in turn, so a completed
// group passes through each of them before it shows on out_tvalid, and the
// pipeline only holds the input when a group is blocked by output back-pressure.
// Configuration writes are always ready and should be made while no group is in
// flight.
module battery_level_hysteresis_monitor #(
  parameter int SAMPLES_PER_READING = blhm_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input samples
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [11:0] sample, [15:12] zero
  input  logic                            in_tuser,   // [0] usb_plugged
  // readings
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [12:0] voltage_mv, [15:13] level
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [blhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blhm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import blhm_pkg::*;

  blhm_cfg_t        cfg;
  blhm_group_t      grp;
  logic             grp_valid, grp_ready;
  logic             mv_valid, mv_ready;
  logic [MV_W-1:0]  mv;
  logic [MV_W-1:0]  res_mv;
  logic [LVL_W-1:0] res_level;

  // register file
  blhm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // running sum, emits one group per SAMPLES_PER_READING samples
  blhm_accum #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .in_usb    (in_tuser),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp_o     (grp)
  );

  // constant multiply-shift to millivolts, charger compensation
  blhm_scale #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp_i     (grp),
    .offset    (cfg.offset),
    .mv_valid  (mv_valid),
    .mv_ready  (mv_ready),
    .mv_o      (mv)
  );

  // level tracking and output register
  blhm_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .mv_valid  (mv_valid),
    .mv_ready  (mv_ready),
    .mv_i      (mv),
    .cfg_i     (cfg),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_mv    (res_mv),
    .res_level (res_level)
  );

  assign out_tdata = {res_level, res_mv};

endmodule

// ----- hdl/blhm_cfg.sv -----
// configuration register file of the battery level monitor
module blhm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [blhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blhm_pkg::CFG_DATA_W-1:0] cfg_data,
  output blhm_pkg::blhm_cfg_t             cfg_o
);
  import blhm_pkg::*;

  blhm_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr[0] <= THR0_RST;
      cfg_r.thr[1] <= THR1_RST;
      cfg_r.thr[2] <= THR2_RST;
      cfg_r.thr[3] <= THR3_RST;
      cfg_r.hyst   <= HYST_RST;
      cfg_r.offset <= OFFSET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THR0:   cfg_r.thr[0] <= cfg_data[THR_W-1:0];
        REG_THR1:   cfg_r.thr[1] <= cfg_data[THR_W-1:0];
        REG_THR2:   cfg_r.thr[2] <= cfg_data[THR_W-1:0];
        REG_THR3:   cfg_r.thr[3] <= cfg_data[THR_W-1:0];
        REG_HYST:   cfg_r.hyst   <= cfg_data[HYST_W-1:0];
        REG_OFFSET: cfg_r.offset <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/blhm_accum.sv -----
// sample accumulator and registered group sum
module blhm_accum #(
  parameter int SAMPLES_PER_READING = blhm_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [blhm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_usb,
  output logic                          grp_valid,
  input  logic                          grp_ready,
  output blhm_pkg::blhm_group_t         grp_o
);
  import blhm_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             grp_valid_r;
  blhm_group_t      grp_r;
  logic             accept, last;

  assign in_ready  = !grp_valid_r || grp_ready;
  assign accept    = in_valid && in_ready;
  assign last      = (cnt_r == CNT_LAST);
  assign sum_nxt   = sum_r + SUM_W'(in_sample);
  assign grp_valid = grp_valid_r;
  assign grp_o     = grp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      grp_valid_r <= 1'b0;
    end else begin
      if (grp_ready) begin
        grp_valid_r <= 1'b0;
      end
      if (accept) begin
        if (last) begin
          sum_r       <= '0;
          cnt_r       <= '0;
          grp_valid_r <= 1'b1;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      grp_r.sum <= sum_nxt;
      grp_r.usb <= in_usb;
    end
  end

endmodule

// ----- hdl/blhm_scale.sv -----
// sum to millivolt scaling by reciprocal multiply, charger offset with floor at zero
module blhm_scale #(
  parameter int SAMPLES_PER_READING = blhm_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      grp_valid,
  output logic                      grp_ready,
  input  blhm_pkg::blhm_group_t     grp_i,
  input  logic [blhm_pkg::OFS_W-1:0] offset,
  output logic                      mv_valid,
  input  logic                      mv_ready,
  output logic [blhm_pkg::MV_W-1:0] mv_o
);
  import blhm_pkg::*;

  // 2^SHIFT exceeds max sum * 256 * n, so the rounded-up reciprocal is exact
  localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam int SHIFT = SUM_W + MV_DEN_SHIFT + CNT_W;
  localparam int PROD_W = SHIFT + MV_W;
  localparam longint unsigned RECIP =
    ((longint'(MV_NUM) << (SHIFT - MV_DEN_SHIFT)) + longint'(SAMPLES_PER_READING) - 1)
    / longint'(SAMPLES_PER_READING);

  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]   mv_raw, mv_nxt;
  logic [MV_W-1:0]   mv_r;
  logic              mv_valid_r;
  logic              accept;

  assign grp_ready = !mv_valid_r || mv_ready;
  assign accept    = grp_valid && grp_ready;
  assign prod      = PROD_W'(grp_i.sum) * PROD_W'(RECIP);
  assign mv_raw    = prod[SHIFT +: MV_W];

  always_comb begin
    mv_nxt = mv_raw;
    if (grp_i.usb) begin
      mv_nxt = (mv_raw > MV_W'(offset)) ? mv_raw - MV_W'(offset) : '0;
    end
  end

  assign mv_valid = mv_valid_r;
  assign mv_o     = mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_valid_r <= 1'b0;
    end else if (grp_ready) begin
      mv_valid_r <= grp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mv_r <= mv_nxt;
    end
  end

endmodule

// ----- hdl/blhm_level.sv -----
// level quantizer with hysteresis and result register
module blhm_level (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       mv_valid,
  output logic                       mv_ready,
  input  logic [blhm_pkg::MV_W-1:0]  mv_i,
  input  blhm_pkg::blhm_cfg_t        cfg_i,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [blhm_pkg::MV_W-1:0]  res_mv,
  output logic [blhm_pkg::LVL_W-1:0] res_level
);
  import blhm_pkg::*;

  localparam int CMP_W = THR_W + 1;

  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               level_init_r;
  logic               res_valid_r;
  logic [MV_W-1:0]    res_mv_r;
  logic [NUM_THR-1:0] below, down, up;
  logic               accept;

  assign mv_ready = !res_valid_r || res_ready;
  assign accept   = mv_valid && mv_ready;

  // compares widened by one bit so threshold +/- margin never wraps
  always_comb begin
    for (int i = 0; i < NUM_THR; i++) begin
      below[i] = mv_i < cfg_i.thr[i];
      down[i]  = (CMP_W'(mv_i) + CMP_W'(cfg_i.hyst)) < CMP_W'(cfg_i.thr[i]);
      up[i]    = CMP_W'(mv_i) > (CMP_W'(cfg_i.thr[i]) + CMP_W'(cfg_i.hyst));
    end
  end

  always_comb begin
    level_nxt = level_r;
    if (!level_init_r) begin
      priority if (below[0]) level_nxt = LEVEL_0;
      else if (below[1])     level_nxt = LEVEL_1;
      else if (below[2])     level_nxt = LEVEL_2;
      else if (below[3])     level_nxt = LEVEL_3;
      else                   level_nxt = LEVEL_4;
    end else begin
      unique case (level_r)
        LEVEL_0: level_nxt = up[0] ? LEVEL_1 : LEVEL_0;
        LEVEL_1: level_nxt = down[0] ? LEVEL_0 : (up[1] ? LEVEL_2 : LEVEL_1);
        LEVEL_2: level_nxt = down[1] ? LEVEL_1 : (up[2] ? LEVEL_3 : LEVEL_2);
        LEVEL_3: level_nxt = down[2] ? LEVEL_2 : (up[3] ? LEVEL_4 : LEVEL_3);
        default: level_nxt = down[3] ? LEVEL_3 : LEVEL_4;
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res_mv    = res_mv_r;
  assign res_level = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= LEVEL_0;
      level_init_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (mv_ready) begin
        res_valid_r <= mv_valid;
      end
      if (accept) begin
        level_r      <= level_nxt;
        level_init_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_mv_r <= mv_i;
    end
  end

endmodule
